// ----- rtl/core/sfb_pkg.sv -----
// Shared types, constants and helpers for the stuffed serial frame builder.
// Used by every module under rtl/core; depends on nothing else.
package sfb_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] SEQ1_CTRL = 8'h40;
  localparam logic [7:0] SEQ0_CTRL = 8'h00;

  localparam int MAX_BEATS   = 6;
  localparam int BEAT_IDX_W  = $clog2(MAX_BEATS);
  localparam int CFG_INDEX_W = 3;

  // Reset values of the configuration registers.
  localparam logic [7:0] ADDRESS_RESET = 8'd3;
  localparam logic [7:0] SET_RESET     = 8'd3;
  localparam logic [7:0] UA_RESET      = 8'd7;
  localparam logic [7:0] DISC_RESET    = 8'd11;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_END     = 2'd2,
    CMD_CONTROL = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_UA  = 2'd1;

  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SET_CTRL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UA_CTRL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DISC_CTRL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEQ_BIT  = 3'd4;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] set_control;
    logic [7:0] ua_control;
    logic [7:0] disc_control;
    logic       sequence_bit;
  } cfg_t;

  // All line bytes caused by one input beat.
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [BEAT_IDX_W-1:0]     last_idx;
    logic                      error;
  } burst_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

// ----- rtl/core/sfb_cfg_regs.sv -----
// Configuration register file of the frame builder.
// Depends on sfb_pkg.
module sfb_cfg_regs
  import sfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_byte <= ADDRESS_RESET;
      cfg.set_control  <= SET_RESET;
      cfg.ua_control   <= UA_RESET;
      cfg.disc_control <= DISC_RESET;
      cfg.sequence_bit <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADDRESS:   cfg.address_byte <= cfg_data;
        REG_SET_CTRL:  cfg.set_control  <= cfg_data;
        REG_UA_CTRL:   cfg.ua_control   <= cfg_data;
        REG_DISC_CTRL: cfg.disc_control <= cfg_data;
        REG_SEQ_BIT:   cfg.sequence_bit <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sfb_encoder.sv -----
// Turns one command beat into the list of line bytes it causes and keeps
// the frame state (open flag, running check). Depends on sfb_pkg.
module sfb_encoder
  import sfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [1:0] control_kind,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output burst_t     burst
);

  logic [7:0] running_check;
  logic [7:0] running_check_next;
  logic       frame_open;
  logic       frame_open_next;

  logic [7:0] ctrl;
  logic [7:0] hdr_check;
  logic [7:0] body;
  logic       esc;
  cmd_t       cmd;

  assign cmd = cmd_t'(command);

  always_comb begin
    priority if (cmd == CMD_START) begin
      ctrl = cfg.sequence_bit ? SEQ1_CTRL : SEQ0_CTRL;
    end else if (control_kind == KIND_SET) begin
      ctrl = cfg.set_control;
    end else if (control_kind == KIND_UA) begin
      ctrl = cfg.ua_control;
    end else begin
      ctrl = cfg.disc_control;
    end
  end

  assign hdr_check = cfg.address_byte ^ ctrl;

  // The one byte of this beat that is subject to stuffing.
  always_comb begin
    unique case (cmd)
      CMD_PAYLOAD: body = data_byte;
      CMD_END:     body = running_check;
      default:     body = hdr_check;
    endcase
  end

  assign esc = needs_escape(body);

  always_comb begin
    burst = '0;
    running_check_next = running_check;
    frame_open_next    = frame_open;
    unique case (cmd)
      CMD_START, CMD_CONTROL: begin
        burst.bytes[0] = FLAG_BYTE;
        burst.bytes[1] = cfg.address_byte;
        burst.bytes[2] = ctrl;
        if (esc) begin
          burst.bytes[3] = ESC_BYTE;
          burst.bytes[4] = body ^ ESC_XOR;
          burst.bytes[5] = FLAG_BYTE;
        end else begin
          burst.bytes[3] = body;
          burst.bytes[4] = FLAG_BYTE;
        end
        if (cmd == CMD_START) begin
          burst.last_idx = esc ? BEAT_IDX_W'(4) : BEAT_IDX_W'(3);
        end else begin
          burst.last_idx = esc ? BEAT_IDX_W'(5) : BEAT_IDX_W'(4);
        end
        running_check_next = '0;
        frame_open_next    = (cmd == CMD_START);
      end
      default: begin
        if (!frame_open) begin
          // Payload or end with no frame open: a single zero error beat.
          burst.error = 1'b1;
        end else begin
          if (esc) begin
            burst.bytes[0] = ESC_BYTE;
            burst.bytes[1] = body ^ ESC_XOR;
            burst.bytes[2] = FLAG_BYTE;
          end else begin
            burst.bytes[0] = body;
            burst.bytes[1] = FLAG_BYTE;
          end
          if (cmd == CMD_PAYLOAD) begin
            burst.last_idx     = esc ? BEAT_IDX_W'(1) : BEAT_IDX_W'(0);
            running_check_next = running_check ^ data_byte;
          end else begin
            burst.last_idx     = esc ? BEAT_IDX_W'(2) : BEAT_IDX_W'(1);
            running_check_next = '0;
            frame_open_next    = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_check <= '0;
      frame_open    <= 1'b0;
    end else if (accept) begin
      running_check <= running_check_next;
      frame_open    <= frame_open_next;
    end
  end

endmodule

// ----- rtl/core/sfb_serializer.sv -----
// Holds the byte list of one command and sends it out one beat per cycle
// while m_tready is high. Depends on sfb_pkg.
module sfb_serializer
  import sfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  burst_t     burst_in,
  output logic       ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,
  output logic       m_tuser    // error
);

  burst_t                burst;
  logic                  valid;
  logic [BEAT_IDX_W-1:0] idx;
  logic                  take_last;

  assign m_tvalid  = valid;
  assign m_tdata   = burst.bytes[idx];
  assign m_tlast   = (idx == burst.last_idx);
  assign m_tuser   = burst.error;
  assign take_last = valid && m_tready && m_tlast;
  // A new list may load in the same cycle the previous final beat leaves.
  assign ready     = !valid || take_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take_last) begin
      valid <= 1'b0;
    end else if (valid && m_tready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= burst.last_idx)
    else $error("beat index beyond end of list");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    valid && !m_tready |=> valid && $stable(idx))
    else $error("beat moved while stalled");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    valid && burst.error |-> burst.last_idx == '0)
    else $error("error list longer than one beat");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("list loaded over pending beats");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take_last && !load |=> !valid)
    else $error("list still valid after final beat");

endmodule

// ----- rtl/core/stuffed_serial_frame_builder_top.sv -----
// Top level of the stuffed serial frame builder.
// Depends on sfb_pkg, sfb_cfg_regs, sfb_encoder and sfb_serializer.
//
//   channel  | dir | beat holds
//   s_*      | in  | tuser: command[1:0], control_kind[3:2]; tdata: data_byte
//   m_*      | out | tdata: out_byte; tlast: last; tuser: error
//   cfg_*    | in  | cfg_index selects register, cfg_data written on cfg_we
//
// A command beat is encoded in the cycle it is accepted and its bytes leave
// one per cycle: 1 to 6 output beats per input beat (payload 1 or 2).
// The next command is taken in the cycle the previous final byte is taken,
// so the output port sets the rate. Reset is synchronous on rst: no frame
// open, check cleared, registers at their defaults. A stall on m_tready holds
// the current byte and closes s_tready until the final byte leaves.
module stuffed_serial_frame_builder_top
  import sfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // data_byte
  input  logic [3:0]             s_tuser,   // command[1:0], control_kind[3:2]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // out_byte
  output logic                   m_tlast,   // last
  output logic                   m_tuser,   // error
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  cfg_t   cfg;
  burst_t burst;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  sfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfb_encoder u_enc (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (s_tuser[1:0]),
    .control_kind (s_tuser[3:2]),
    .data_byte    (s_tdata),
    .cfg          (cfg),
    .burst        (burst)
  );

  sfb_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .burst_in (burst),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- tb/tb_stuffed_serial_frame_builder_top.sv -----
// Self-checking testbench for stuffed_serial_frame_builder_top.
// It predicts every line beat, compares the output stream against that prediction,
// and runs under several register settings and flow-control patterns. Needs sfb_pkg.
module tb_stuffed_serial_frame_builder_top;
  import sfb_pkg::*;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] kind;
    logic [7:0] data;
  } command_beat_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last;
    logic       err;
  } line_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic [3:0]             s_tuser = 4'h0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = 8'h00;

  stuffed_serial_frame_builder_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  command_beat_t pending_commands[$];
  line_beat_t    line_beats_due[$];
  logic [7:0]    burst_bytes[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatches = 0;
  logic        command_fire = 1'b0;

  // Predictor state: register copy, running XOR of the payload and the open flag.
  cfg_t        link_cfg;
  logic [7:0]  payload_xor;
  logic        frame_open;

  // Header check, payload and trailing check: flag and escape bytes are escaped.
  function automatic void append_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      burst_bytes.push_back(ESC_BYTE);
      burst_bytes.push_back(b ^ ESC_XOR);
    end else begin
      burst_bytes.push_back(b);
    end
  endfunction

  function automatic void predict_line_beats(input cmd_t cmd, input logic [1:0] kind,
                                             input logic [7:0] data);
    logic [7:0] ctrl;
    burst_bytes.delete();
    if ((cmd == CMD_PAYLOAD || cmd == CMD_END) && !frame_open) begin
      line_beats_due.push_back('{line_byte: 8'h00, last: 1'b1, err: 1'b1});
      return;
    end
    case (cmd)
      CMD_START: begin
        ctrl = link_cfg.sequence_bit ? SEQ1_CTRL : SEQ0_CTRL;
        burst_bytes.push_back(FLAG_BYTE);
        burst_bytes.push_back(link_cfg.address_byte);
        burst_bytes.push_back(ctrl);
        append_stuffed(link_cfg.address_byte ^ ctrl);
        payload_xor = 8'h00;
        frame_open = 1'b1;
      end
      CMD_PAYLOAD: begin
        append_stuffed(data);
        payload_xor = payload_xor ^ data;
      end
      CMD_END: begin
        append_stuffed(payload_xor);
        burst_bytes.push_back(FLAG_BYTE);
        payload_xor = 8'h00;
        frame_open = 1'b0;
      end
      default: begin
        // The spare kind code falls through to DISC.
        case (kind)
          KIND_SET: ctrl = link_cfg.set_control;
          KIND_UA:  ctrl = link_cfg.ua_control;
          default:  ctrl = link_cfg.disc_control;
        endcase
        burst_bytes.push_back(FLAG_BYTE);
        burst_bytes.push_back(link_cfg.address_byte);
        burst_bytes.push_back(ctrl);
        append_stuffed(link_cfg.address_byte ^ ctrl);
        burst_bytes.push_back(FLAG_BYTE);
        payload_xor = 8'h00;
        frame_open = 1'b0;
      end
    endcase
    foreach (burst_bytes[i])
      line_beats_due.push_back('{line_byte: burst_bytes[i],
                                 last: (i == burst_bytes.size() - 1), err: 1'b0});
  endfunction

  function automatic void report_mismatch(input line_beat_t want, input logic missing);
    mismatches++;
    if (mismatches <= 10) begin
      if (missing)
        $display("unexpected output beat: byte %02h last %0b err %0b",
                 m_tdata, m_tlast, m_tuser);
      else
        $display("mismatch: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                 want.line_byte, want.last, want.err, m_tdata, m_tlast, m_tuser);
    end
  endfunction

  // Monitor and predictor: everything is sampled on the rising edge.
  always @(posedge clk) begin : monitor
    line_beat_t want;
    command_fire = !rst && s_tvalid && s_tready;
    if (rst) begin
      link_cfg.address_byte = ADDRESS_RESET;
      link_cfg.set_control  = SET_RESET;
      link_cfg.ua_control   = UA_RESET;
      link_cfg.disc_control = DISC_RESET;
      link_cfg.sequence_bit = 1'b0;
      payload_xor = 8'h00;
      frame_open = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ADDRESS:   link_cfg.address_byte = cfg_data;
          REG_SET_CTRL:  link_cfg.set_control  = cfg_data;
          REG_UA_CTRL:   link_cfg.ua_control   = cfg_data;
          REG_DISC_CTRL: link_cfg.disc_control = cfg_data;
          REG_SEQ_BIT:   link_cfg.sequence_bit = cfg_data[0];
          default: ;
        endcase
      end
      if (command_fire)
        predict_line_beats(cmd_t'(s_tuser[1:0]), s_tuser[3:2], s_tdata);
      if (m_tvalid && m_tready) begin
        if (line_beats_due.size() == 0) begin
          want = '0;
          report_mismatch(want, 1'b1);
        end else begin
          want = line_beats_due.pop_front();
          if (m_tdata !== want.line_byte || m_tlast !== want.last || m_tuser !== want.err)
            report_mismatch(want, 1'b0);
        end
      end
    end
  end

  // Driver: a new beat is offered on the falling edge once the previous one was taken.
  always @(negedge clk) begin : driver
    command_beat_t next_cmd;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || command_fire) begin
      if (pending_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_cmd = pending_commands.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= {next_cmd.kind, next_cmd.cmd};
        s_tdata  <= next_cmd.data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic void queue_cmd(input cmd_t cmd, input logic [1:0] kind,
                                    input logic [7:0] data);
    pending_commands.push_back('{cmd: cmd, kind: kind, data: data});
  endfunction

  // Payload bytes lean toward the values that need escaping and their escaped forms.
  function automatic logic [7:0] pick_payload();
    logic [7:0] hot[4] = '{8'h7E, 8'h7D, 8'h5E, 8'h5D};
    if ($urandom_range(3) == 0)
      return hot[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  // Every data-frame flavor and every control kind under the current register setting.
  task automatic queue_frame_tour();
    queue_cmd(CMD_START, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd3, 8'h7E);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h7D);
    queue_cmd(CMD_END, 2'd1, 8'hFF);
    for (int k = 0; k < 4; k++)
      queue_cmd(CMD_CONTROL, 2'(k), 8'($urandom_range(255)));
  endtask

  // Mostly well-formed data frames, some control frames, some noise and broken frames.
  task automatic queue_random_traffic(input int count);
    int queued;
    int pick;
    int payload_len;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_cmd(CMD_START, 2'($urandom_range(3)), 8'($urandom_range(255)));
        payload_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (payload_len) queue_cmd(CMD_PAYLOAD, 2'($urandom_range(3)), pick_payload());
        queued += 1 + payload_len;
        // A few frames are left open so the next command abandons them.
        if ($urandom_range(9) != 0) begin
          queue_cmd(CMD_END, 2'($urandom_range(3)), 8'($urandom_range(255)));
          queued++;
        end
      end else if (pick < 85) begin
        queue_cmd(CMD_CONTROL, 2'($urandom_range(3)), 8'($urandom_range(255)));
        queued++;
      end else begin
        queue_cmd(cmd_t'($urandom_range(3)), 2'($urandom_range(3)), pick_payload());
        queued++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_commands.size() != 0 || s_tvalid || line_beats_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int random_count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    queue_frame_tour();
    queue_random_traffic(random_count);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults, no flow control: error cases, empty frame, restarts.
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h55);
    queue_cmd(CMD_END, 2'd2, 8'h00);
    queue_cmd(CMD_START, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd1, 8'hFF);
    queue_cmd(CMD_PAYLOAD, 2'd2, 8'h7E);
    queue_cmd(CMD_PAYLOAD, 2'd3, 8'h7D);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h5E);
    queue_cmd(CMD_END, 2'd0, 8'h00);
    queue_cmd(CMD_START, 2'd3, 8'hFF);
    queue_cmd(CMD_END, 2'd0, 8'h00);
    queue_cmd(CMD_START, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'hAA);
    queue_cmd(CMD_START, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h7D);
    queue_cmd(CMD_END, 2'd0, 8'h00);
    queue_cmd(CMD_START, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h12);
    queue_cmd(CMD_CONTROL, KIND_UA, 8'h00);
    queue_cmd(CMD_END, 2'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 2'd0, 8'h34);
    run_phase(0, 0, 45);

    // Header checks land on the flag value, both for data and SET frames.
    write_reg(REG_ADDRESS, 8'h7E);
    write_reg(REG_SET_CTRL, 8'h00);
    write_reg(REG_UA_CTRL, 8'hFF);
    write_reg(REG_DISC_CTRL, 8'h7D);
    write_reg(REG_SEQ_BIT, 8'h00);
    run_phase(51, 0, 60);

    // Data header checks land on the escape value, SET checks on the flag value.
    write_reg(REG_ADDRESS, 8'h3D);
    write_reg(REG_SEQ_BIT, 8'h01);
    write_reg(REG_SET_CTRL, 8'h43);
    write_reg(REG_UA_CTRL, 8'h00);
    write_reg(REG_DISC_CTRL, 8'hFF);
    run_phase(0, 51, 60);

    write_reg(REG_ADDRESS, 8'h00);
    write_reg(REG_SEQ_BIT, 8'($urandom_range(255)));
    write_reg(REG_SET_CTRL, 8'($urandom_range(255)));
    write_reg(REG_UA_CTRL, 8'h7E);
    write_reg(REG_DISC_CTRL, 8'($urandom_range(255)));
    run_phase(27, 27, 60);

    write_reg(REG_ADDRESS, 8'hFF);
    write_reg(REG_SEQ_BIT, 8'hFF);
    write_reg(REG_SET_CTRL, 8'($urandom_range(255)));
    write_reg(REG_UA_CTRL, 8'($urandom_range(255)));
    write_reg(REG_DISC_CTRL, 8'h82);
    run_phase(0, 0, 50);

    if (mismatches == 0 && line_beats_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sfb_pkg.sv
rtl/core/sfb_cfg_regs.sv
rtl/core/sfb_encoder.sv
rtl/core/sfb_serializer.sv
rtl/core/stuffed_serial_frame_builder_top.sv
tb/tb_stuffed_serial_frame_builder_top.sv
